@@ hw/rtl/lms_adaptive_fir_with_hilbert_defines.svh @@
// assertion macros for the lms hilbert block
// no dependencies
`ifndef LMS_ADAPTIVE_FIR_WITH_HILBERT_DEFINES_SVH
`define LMS_ADAPTIVE_FIR_WITH_HILBERT_DEFINES_SVH
// implication checked every clock outside reset
`define LMSH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lmsh assertion failed");
// implication checked on the following clock
`define LMSH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lmsh assertion failed");
`endif

@@ hw/rtl/lmsh_pkg.sv @@
// shared types, constants, the hilbert rom and a saturation helper for the lms hilbert block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lmsh_pkg;
  localparam int unsigned TapsDefault = 128;
  localparam int unsigned Depth = 128;
  localparam int unsigned AddrW = 7;
  localparam logic [15:0] StepReset = 16'd328;
  localparam int unsigned FifoDepth = 2;

  typedef struct packed {
    logic signed [15:0] reference_sample;
    logic signed [15:0] measured_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] error_sample;
    logic signed [15:0] anti_noise_sample;
    logic signed [15:0] shifted_anti_noise;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle, StLoad, StEst, StUpd, StHil, StOut
  } core_state_e;

  function automatic logic signed [15:0] rom_at(input logic [6:0] i);
    logic [14:0] m;
    logic [5:0] k;
    k = i[6] ? 6'(7'd127 - i) : i[5:0];
    case (k)
      6'd0: m = 15'd0;     6'd1: m = 15'd0;     6'd2: m = 15'd1;     6'd3: m = 15'd0;
      6'd4: m = 15'd1;     6'd5: m = 15'd0;     6'd6: m = 15'd2;     6'd7: m = 15'd1;
      6'd8: m = 15'd4;     6'd9: m = 15'd1;     6'd10: m = 15'd6;    6'd11: m = 15'd2;
      6'd12: m = 15'd8;    6'd13: m = 15'd4;    6'd14: m = 15'd12;   6'd15: m = 15'd6;
      6'd16: m = 15'd17;   6'd17: m = 15'd8;    6'd18: m = 15'd23;   6'd19: m = 15'd12;
      6'd20: m = 15'd30;   6'd21: m = 15'd16;   6'd22: m = 15'd40;   6'd23: m = 15'd23;
      6'd24: m = 15'd51;   6'd25: m = 15'd30;   6'd26: m = 15'd66;   6'd27: m = 15'd40;
      6'd28: m = 15'd83;   6'd29: m = 15'd53;   6'd30: m = 15'd104;  6'd31: m = 15'd68;
      6'd32: m = 15'd128;  6'd33: m = 15'd87;   6'd34: m = 15'd157;  6'd35: m = 15'd110;
      6'd36: m = 15'd191;  6'd37: m = 15'd139;  6'd38: m = 15'd231;  6'd39: m = 15'd173;
      6'd40: m = 15'd277;  6'd41: m = 15'd215;  6'd42: m = 15'd332;  6'd43: m = 15'd266;
      6'd44: m = 15'd398;  6'd45: m = 15'd329;  6'd46: m = 15'd476;  6'd47: m = 15'd407;
      6'd48: m = 15'd572;  6'd49: m = 15'd506;  6'd50: m = 15'd692;  6'd51: m = 15'd635;
      6'd52: m = 15'd848;  6'd53: m = 15'd810;  6'd54: m = 15'd1062; 6'd55: m = 15'd1061;
      6'd56: m = 15'd1378; 6'd57: m = 15'd1458; 6'd58: m = 15'd1908; 6'd59: m = 15'd2191;
      6'd60: m = 15'd3015; 6'd61: m = 15'd4067; 6'd62: m = 15'd7012; 6'd63: m = 15'd20778;
      default: m = 15'd0;
    endcase
    rom_at = i[6] ? $signed({1'b0, m}) : -$signed({1'b0, m});
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) sat16 = 16'sh7fff;
    else if (v < -48'sd32768) sat16 = 16'sh8000;
    else sat16 = v[15:0];
  endfunction
endpackage
`default_nettype wire

@@ hw/rtl/lms_adaptive_fir_with_hilbert.sv @@
// lms adaptive fir noise canceller with hilbert post filter, top level
// depends on lmsh_pkg, lmsh_fifo, lmsh_core
// channels: input queue (push/full) takes a reference and a measured sample;
// result queue (empty/pop) gives error, anti-noise and hilbert-shifted
// anti-noise. config channel (valid/ready) writes the step size, always ready.
// an input request enters a two-entry queue, the back end pops it and runs
// three passes of TAPS taps each (estimate, weight update, hilbert fir)
// through one shared read/multiply loop, one tap at a time; the back end
// finishes a request and hands its result to the result queue before it
// pops the next one, while later requests wait in the input queue.
// results go into a two-entry result queue; when the receiver stops popping
// the result queue fills, the back end waits, then the input queue fills.
// after reset a clearing pass zeroes the weight and history
// memories; requests are queued but not processed until it is done.
// step size resets to 328.
`timescale 1ns / 1ps
`default_nettype none
module lms_adaptive_fir_with_hilbert #(
  parameter int unsigned TAPS = lmsh_pkg::TapsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  input  wire lmsh_pkg::in_item_t   in_item_i,
  output logic                      full,
  output logic                      empty,
  input  wire logic                 pop,
  output lmsh_pkg::out_item_t       out_item_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [15:0]          cfg_data_i
);
  logic [15:0] step_q;
  lmsh_pkg::in_item_t q_data;
  logic q_empty, q_pop, r_push, r_full;
  lmsh_pkg::out_item_t r_data;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) step_q <= lmsh_pkg::StepReset;
    else if (cfg_valid_i) step_q <= cfg_data_i;
  end

  lmsh_fifo #(.W($bits(lmsh_pkg::in_item_t))) u_in_q (
    .clk_i, .rst_ni, .push_i(push), .data_i(in_item_i), .full_o(full),
    .pop_i(q_pop), .data_o(q_data), .empty_o(q_empty)
  );

  lmsh_core #(.TAPS(TAPS)) u_core (
    .clk_i, .rst_ni, .step_i(step_q), .req_valid_i(!q_empty), .req_i(q_data),
    .req_pop_o(q_pop), .res_valid_o(r_push), .res_o(r_data), .res_full_i(r_full)
  );

  lmsh_fifo #(.W($bits(lmsh_pkg::out_item_t))) u_out_q (
    .clk_i, .rst_ni, .push_i(r_push), .data_i(r_data), .full_o(r_full),
    .pop_i(pop), .data_o(out_item_o), .empty_o(empty)
  );
endmodule
`default_nettype wire

@@ hw/rtl/lmsh_fifo.sv @@
// small two-entry queue, used for the requests and for the results
// depends on lmsh_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "lms_adaptive_fir_with_hilbert_defines.svh"
module lmsh_fifo #(
  parameter int unsigned W = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic [W-1:0]      data_o,
  output logic              empty_o
);
  localparam int unsigned D = lmsh_pkg::FifoDepth;
  logic [W-1:0] mem_q [D];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;

  assign full_o  = (cnt_q == 2'(D));
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wp_q <= ~wp_q;
      if (pop_i && !empty_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && !empty_o);
    end
  end

  `LMSH_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= 2'(D))
  `LMSH_ASSERT_NEXT(a_full_hold, clk_i, rst_ni, full_o && !pop_i, full_o)
  `LMSH_ASSERT_NEXT(a_empty_hold, clk_i, rst_ni, empty_o && !push_i, empty_o)
endmodule
`default_nettype wire

@@ hw/rtl/lmsh_core.sv @@
// back end: estimate, weight update and hilbert passes over the stores
// depends on lmsh_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "lms_adaptive_fir_with_hilbert_defines.svh"
module lmsh_core #(
  parameter int unsigned TAPS = lmsh_pkg::TapsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [15:0]         step_i,
  input  wire logic                req_valid_i,
  input  wire lmsh_pkg::in_item_t  req_i,
  output logic                     req_pop_o,
  output logic                     res_valid_o,
  output lmsh_pkg::out_item_t      res_o,
  input  wire logic                res_full_i
);
  localparam int unsigned AW = lmsh_pkg::AddrW;
  localparam logic [AW-1:0] LastTap = AW'(TAPS - 1);
  localparam logic [AW:0] ClrEnd = (AW+1)'(lmsh_pkg::Depth);

  // memories, cleared by a sweep after reset
  logic signed [31:0] w_mem [lmsh_pkg::Depth];
  logic signed [15:0] x_mem [lmsh_pkg::Depth];
  logic signed [15:0] a_mem [lmsh_pkg::Depth];

  lmsh_pkg::core_state_e st_q, st_d;
  logic [AW:0]   clr_q;
  logic [AW-1:0] pos_q, j_q, j_rd;
  logic          rd_vld_q, rd_last_q;
  logic [AW-1:0] j_wr_q;
  logic signed [31:0] w_rd_q;
  logic signed [15:0] x_rd_q, a_rd_q;
  logic signed [15:0] rom_q;
  logic signed [47:0] prod_q;
  logic          prod_vld_q, prod_last_q;
  logic [AW-1:0] prod_j_q;
  logic signed [31:0] wold_q;
  logic signed [55:0] acc_q;
  logic signed [15:0] meas_q, err_q, anti_q;
  logic          issue;
  logic [AW-1:0] tidx;

  // tap j reads history entry pos - j modulo taps
  always_comb begin
    logic [AW:0] t;
    t = {1'b0, pos_q} + (AW+1)'(TAPS) - {1'b0, j_q};
    if (t >= (AW+1)'(TAPS)) t = t - (AW+1)'(TAPS);
    tidx = t[AW-1:0];
  end
  assign j_rd = j_q;

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      lmsh_pkg::StIdle: if (clr_q == ClrEnd && req_valid_i) st_d = lmsh_pkg::StLoad;
      lmsh_pkg::StLoad: st_d = lmsh_pkg::StEst;
      lmsh_pkg::StEst:  if (prod_vld_q && prod_last_q) st_d = lmsh_pkg::StUpd;
      lmsh_pkg::StUpd:  if (prod_vld_q && prod_last_q) st_d = lmsh_pkg::StHil;
      lmsh_pkg::StHil:  if (prod_vld_q && prod_last_q) st_d = lmsh_pkg::StOut;
      lmsh_pkg::StOut:  if (!res_full_i) st_d = lmsh_pkg::StIdle;
      default: st_d = lmsh_pkg::StIdle;
    endcase
  end

  // outputs
  always_comb begin
    req_pop_o = (st_q == lmsh_pkg::StLoad);
    res_valid_o = (st_q == lmsh_pkg::StOut) && !res_full_i;
    res_o.error_sample = err_q;
    res_o.anti_noise_sample = anti_q;
    res_o.shifted_anti_noise = lmsh_pkg::sat16(48'((acc_q + 56'sd16384) >>> 15));
    issue = (st_q == lmsh_pkg::StEst || st_q == lmsh_pkg::StUpd ||
             st_q == lmsh_pkg::StHil) && !(j_q == LastTap && rd_vld_q) &&
            !prod_vld_q && !rd_vld_q;
  end

  // read stage, one tap at a time through a 3-stage loop
  always_ff @(posedge clk_i) begin
    if (issue) begin
      w_rd_q <= w_mem[j_rd];
      x_rd_q <= x_mem[tidx];
      a_rd_q <= a_mem[tidx];
      rom_q  <= lmsh_pkg::rom_at(j_rd);
      j_wr_q <= j_q;
    end
    if (rd_vld_q) begin
      prod_j_q <= j_wr_q;
      wold_q <= w_rd_q;
      case (st_q)
        lmsh_pkg::StEst: prod_q <= 48'(w_rd_q * x_rd_q);
        lmsh_pkg::StUpd: prod_q <= 48'($signed({1'b0, step_i}) * err_q);
        lmsh_pkg::StHil: prod_q <= 48'(rom_q * a_rd_q);
        default: prod_q <= '0;
      endcase
    end
  end

  // stage outputs and accumulation
  logic signed [15:0] x_mem_rd_hold;
  logic signed [63:0] upd_p;
  logic signed [63:0] wsum;
  logic signed [31:0] wnew;
  always_comb begin
    upd_p = 64'(prod_q) * 64'(x_mem_rd_hold);
    wsum = 64'(wold_q) + ((upd_p + 64'sd32768) >>> 16);
    if (wsum > 64'sd2147483647) wnew = 32'sh7fffffff;
    else if (wsum < -64'sd2147483648) wnew = 32'sh80000000;
    else wnew = wsum[31:0];
  end
  always_ff @(posedge clk_i) if (rd_vld_q) x_mem_rd_hold <= x_rd_q;

  // last tap product joins the sum here
  logic signed [47:0] est_w;
  always_comb est_w = 48'((acc_q + 56'(prod_q) + 56'sd536870912) >>> 30);

  always_ff @(posedge clk_i) begin
    if (st_q == lmsh_pkg::StLoad) begin
      x_mem[pos_q] <= req_i.reference_sample;
      meas_q <= req_i.measured_sample;
    end
    if (st_q == lmsh_pkg::StEst && prod_vld_q && prod_last_q) begin
      err_q  <= lmsh_pkg::sat16(48'(meas_q) - est_w);
      anti_q <= lmsh_pkg::sat16(-est_w);
      a_mem[pos_q] <= lmsh_pkg::sat16(-est_w);
    end
    if (st_q == lmsh_pkg::StUpd && prod_vld_q) w_mem[prod_j_q] <= wnew;
    if (clr_q != ClrEnd) begin
      w_mem[clr_q[AW-1:0]] <= '0;
      x_mem[clr_q[AW-1:0]] <= '0;
      a_mem[clr_q[AW-1:0]] <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= lmsh_pkg::StIdle;
      clr_q <= '0;
      pos_q <= '0;
      j_q <= '0;
      rd_vld_q <= 1'b0;
      rd_last_q <= 1'b0;
      prod_vld_q <= 1'b0;
      prod_last_q <= 1'b0;
      acc_q <= '0;
    end else begin
      st_q <= st_d;
      if (clr_q != ClrEnd) clr_q <= clr_q + 1'b1;
      rd_vld_q <= issue;
      rd_last_q <= issue && (j_q == LastTap);
      prod_vld_q <= rd_vld_q;
      prod_last_q <= rd_last_q;
      if (issue) j_q <= (j_q == LastTap) ? '0 : j_q + 1'b1;
      if (st_q == lmsh_pkg::StLoad || st_d != st_q) j_q <= '0;
      if (st_q == lmsh_pkg::StLoad) acc_q <= '0;
      else if (st_q == lmsh_pkg::StEst && prod_vld_q && prod_last_q) acc_q <= '0;
      else if (st_q == lmsh_pkg::StEst && prod_vld_q) acc_q <= acc_q + 56'(prod_q);
      else if (st_q == lmsh_pkg::StHil && prod_vld_q) acc_q <= acc_q + 56'(prod_q);
      if (st_q == lmsh_pkg::StOut && !res_full_i) begin
        pos_q <= (pos_q == LastTap) ? '0 : pos_q + 1'b1;
      end
    end
  end

  `LMSH_ASSERT_IMP(a_no_pop_clear, clk_i, rst_ni, clr_q != ClrEnd, !req_pop_o)
  `LMSH_ASSERT_IMP(a_pos_range, clk_i, rst_ni, 1'b1, pos_q <= LastTap)
  `LMSH_ASSERT_IMP(a_res_full, clk_i, rst_ni, res_valid_o, !res_full_i)
endmodule
`default_nettype wire

@@ tb/lmsh_scoreboard.sv @@
// scoreboard for the lms hilbert block: predicts each result from accepted requests
// and compares it field by field with what the result queue delivers
// depends on lmsh_pkg
`timescale 1ns / 1ps
module lmsh_scoreboard (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  logic                full,
  input  lmsh_pkg::in_item_t  in_item_i,
  input  logic                pop,
  input  logic                empty,
  input  lmsh_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i,
  output int                  fail_count,
  output int                  pending
);
  import lmsh_pkg::*;

  localparam int NumTaps = 128;
  localparam int HilbertMag [64] = '{
    0, 0, 1, 0, 1, 0, 2, 1, 4, 1, 6, 2, 8, 4, 12, 6,
    17, 8, 23, 12, 30, 16, 40, 23, 51, 30, 66, 40, 83, 53, 104, 68,
    128, 87, 157, 110, 191, 139, 231, 173, 277, 215, 332, 266, 398, 329, 476, 407,
    572, 506, 692, 635, 848, 810, 1062, 1061, 1378, 1458, 1908, 2191, 3015, 4067, 7012,
    20778};

  logic signed [31:0] weight [NumTaps];
  logic signed [15:0] ref_hist [NumTaps];
  logic signed [15:0] anti_hist [NumTaps];
  int unsigned        head;
  logic [15:0]        mu;
  out_item_t          expected_q [$];

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint hilbert_coef(input int j);
    if (j < 64) return -longint'(HilbertMag[j]);
    return longint'(HilbertMag[127 - j]);
  endfunction

  // advance the canceller by one sample pair and return the expected result
  function automatic out_item_t cancel_sample(input in_item_t it);
    longint acc, est, prod;
    int idx;
    out_item_t r;
    ref_hist[head] = it.reference_sample;
    acc = 0;
    for (int j = 0; j < NumTaps; j++) begin
      idx = (head + NumTaps - j) % NumTaps;
      acc += longint'(weight[j]) * longint'(ref_hist[idx]);
    end
    est = (acc + (64'sd1 <<< 29)) >>> 30;
    r.error_sample = clip16(longint'(it.measured_sample) - est);
    r.anti_noise_sample = clip16(-est);
    for (int j = 0; j < NumTaps; j++) begin
      idx = (head + NumTaps - j) % NumTaps;
      prod = longint'(mu) * longint'(r.error_sample) * longint'(ref_hist[idx]);
      weight[j] = clip32(longint'(weight[j]) + ((prod + 64'sd32768) >>> 16));
    end
    anti_hist[head] = r.anti_noise_sample;
    acc = 0;
    for (int j = 0; j < NumTaps; j++) begin
      idx = (head + NumTaps - j) % NumTaps;
      acc += hilbert_coef(j) * longint'(anti_hist[idx]);
    end
    r.shifted_anti_noise = clip16((acc + 64'sd16384) >>> 15);
    head = (head + 1) % NumTaps;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_r;
    if (!rst_ni) begin
      for (int j = 0; j < NumTaps; j++) begin
        weight[j] = '0;
        ref_hist[j] = '0;
        anti_hist[j] = '0;
      end
      head = 0;
      mu = StepReset;
      expected_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result %h with no request pending", $time, out_item_o);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_item_o !== exp_r) begin
            if (out_item_o.error_sample !== exp_r.error_sample)
              $display("%0t: error_sample expected %0d got %0d", $time,
                       exp_r.error_sample, out_item_o.error_sample);
            if (out_item_o.anti_noise_sample !== exp_r.anti_noise_sample)
              $display("%0t: anti_noise_sample expected %0d got %0d", $time,
                       exp_r.anti_noise_sample, out_item_o.anti_noise_sample);
            if (out_item_o.shifted_anti_noise !== exp_r.shifted_anti_noise)
              $display("%0t: shifted_anti_noise expected %0d got %0d", $time,
                       exp_r.shifted_anti_noise, out_item_o.shifted_anti_noise);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (push && !full) expected_q.push_back(cancel_sample(in_item_i));
      // step size applies to requests accepted after the write
      if (cfg_valid_i && cfg_ready_o) mu = cfg_data_i;
      pending <= expected_q.size();
    end
  end
endmodule

@@ tb/lms_adaptive_fir_with_hilbert_tb.sv @@
// testbench top for the lms hilbert block: clock, reset, request and config
// stimulus, result popping and verdict; depends on lmsh_pkg, lmsh_scoreboard and the rtl
`timescale 1ns / 1ps
module lms_adaptive_fir_with_hilbert_tb;
  import lmsh_pkg::*;

  localparam int DrainCycles = 3000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  in_item_t   in_item_i = '0;
  logic       full, empty;
  logic       pop = 1'b0;
  out_item_t  out_item_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  int         fail_count, pending;
  int         sent = 0;
  bit         burst = 1'b0;

  lms_adaptive_fir_with_hilbert dut (
    .clk_i, .rst_ni, .push, .in_item_i, .full, .empty, .pop, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  lmsh_scoreboard u_scoreboard (
    .clk_i, .rst_ni, .push, .full, .in_item_i, .pop, .empty, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i, .fail_count, .pending
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_sample(input logic [15:0] ref_s, input logic [15:0] meas_s);
    push <= 1'b1;
    in_item_i <= '{reference_sample: ref_s, measured_sample: meas_s};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent++;
    if (!burst && $urandom_range(99) < 18) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic write_step(input logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // receiver: random pops, one long hold-off so the queues fill and push stalls
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held && sent >= 300) begin
        held = 1'b1;
        hold = 6000;
      end
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else begin
        pop <= burst || ($urandom_range(99) >= 18);
      end
    end
  end

  initial begin
    logic [15:0] steps [5];
    logic [15:0] r, m;
    int amp;
    steps = '{16'd0, 16'hffff, 16'd1, 16'd0, 16'd328};
    steps[3] = 16'($urandom_range(65535));
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_step(16'd328);
    // directed: extremes, impulses and sign corners
    send_sample(16'h7fff, 16'h7fff);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h7fff, 16'h8000);
    send_sample(16'h8000, 16'h7fff);
    send_sample(16'hffff, 16'h0001);
    send_sample(16'h0001, 16'hffff);
    for (int i = 0; i < 6; i++) send_sample(16'h0000, 16'h0000);
    for (int i = 0; i < 6; i++) send_sample(16'h4000, 16'hc000);
    drain();
    // large step: weight and output saturation
    write_step(16'hffff);
    for (int i = 0; i < 6; i++) send_sample(16'h7fff, 16'h8000);
    drain();
    for (int p = 0; p < 5; p++) begin
      write_step(steps[p]);
      for (int i = 0; i < 275; i++) begin
        burst = (p == 2 && i >= 50 && i < 200);
        amp = $urandom_range(3);
        r = 16'($urandom_range(65535));
        m = 16'($urandom_range(65535));
        if (amp == 0) begin
          r = 16'($signed(r) >>> 6);
          m = 16'($signed(m) >>> 6);
        end
        send_sample(r, m);
      end
      burst = 1'b0;
      drain();
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
